// ----- sv/snil_pkg.sv -----
package snil_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int POS_W       = 32;
  localparam int LEN_W       = 20;
  localparam int ID_W        = 11;

  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_LOCATED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_LOCATE = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [POS_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } snil_mem_req_t;

endpackage

// ----- sv/snil_mem.sv -----
module snil_mem (
  input  logic                        clk,
  input  snil_pkg::snil_mem_req_t     req,
  output logic [snil_pkg::POS_W-1:0]  rd_data
);
  import snil_pkg::*;

  logic [POS_W-1:0] mem [TABLE_DEPTH];
  logic [POS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/strand_node_interval_locator.sv -----
// Sequence: an append is written straight to the output register; a locate runs P
//   binary-search probes in S_SRCH, at most ceil(log2(entry count)), 10 at full depth,
//   then S_DONE loads the output register; an exact boundary hit closes the window early.
// Throughput: one item at a time; appends go back to back unless the output stalls.
//   The search is bound by the memory's single read port, one probe per cycle.
// Reset (rst_n, synchronous, active low): entry count 1, last boundary 0, output empty.
//   Boundary memory needs no clearing; slot zero is kept in a register as 0.
module strand_node_interval_locator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [snil_pkg::LEN_W-1:0]    in_node_length,
  input  logic [snil_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [snil_pkg::ID_W-1:0] out_node_id,
  output logic [snil_pkg::POS_W-1:0]    out_offset,
  output logic [1:0]                    out_status
);
  import snil_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // table bookkeeping
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;

  // search window: lo is the best slot so far, hi is exclusive
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [POS_W-1:0]  lo_b_r, lo_b_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [POS_W-1:0]        out_off_r, out_off_nxt;
  logic [1:0]              out_st_r, out_st_nxt;

  snil_mem_req_t    mreq;
  logic [POS_W-1:0] rd_data;

  logic             out_free;
  logic             in_acc;
  logic [POS_W:0]   app_sum;
  logic [CNT_W:0]   mid_sum;
  logic [ID_W-1:0]  mag;

  snil_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // new boundary: last + length + separator, one spare bit flags overflow
  assign app_sum = {1'b0, last_r} + {{(POS_W+1-LEN_W){1'b0}}, in_node_length}
                   + {{POS_W{1'b0}}, 1'b1};

  // node number magnitude (slot + 2) / 2, sign from the strand bit
  assign mag = ({{(ID_W-ADDR_W){1'b0}}, lo_r} + ID_W'(2)) >> 1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    lo_b_nxt      = lo_b_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_off_nxt   = out_off_r;
    out_st_nxt    = out_st_r;
    mreq          = '0;
    mid_sum       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_APPEND) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = '0;
            out_off_nxt   = '0;
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              out_st_nxt = ST_FULL;
            end else if (app_sum[POS_W]) begin
              out_st_nxt = ST_OVERFLOW;
            end else begin
              out_st_nxt  = ST_APPENDED;
              mreq.we     = 1'b1;
              mreq.waddr  = count_r[ADDR_W-1:0];
              mreq.wdata  = app_sum[POS_W-1:0];
              last_nxt    = app_sum[POS_W-1:0];
              count_nxt   = count_r + CNT_W'(1);
            end
          end else begin
            pos_nxt  = in_position;
            lo_nxt   = '0;
            hi_nxt   = count_r;
            lo_b_nxt = '0;
            // first probe at count/2; a single entry needs none
            mid_nxt  = ADDR_W'(count_r >> 1);
            if (count_r > CNT_W'(1)) begin
              mreq.re    = 1'b1;
              mreq.raddr = ADDR_W'(count_r >> 1);
              state_nxt  = S_SRCH;
            end else begin
              state_nxt  = S_DONE;
            end
          end
        end
      end

      S_SRCH: begin
        if (rd_data < pos_r) begin
          lo_nxt   = mid_r;
          lo_b_nxt = rd_data;
        end else if (rd_data > pos_r) begin
          hi_nxt   = {1'b0, mid_r};
        end else begin
          lo_nxt   = mid_r;
          hi_nxt   = {1'b0, mid_r} + CNT_W'(1);
          lo_b_nxt = rd_data;
        end
        mid_sum = {2'b00, lo_nxt} + {1'b0, hi_nxt};
        mid_nxt = mid_sum[ADDR_W:1];
        if (({1'b0, lo_nxt} + CNT_W'(1)) < hi_nxt) begin
          mreq.re    = 1'b1;
          mreq.raddr = mid_sum[ADDR_W:1];
        end else begin
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = lo_r[0] ? -$signed(mag) : $signed(mag);
          out_off_nxt   = pos_r - lo_b_r;
          out_st_nxt    = ST_LOCATED;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    lo_b_r    <= lo_b_nxt;
    pos_r     <= pos_nxt;
    out_id_r  <= out_id_nxt;
    out_off_r <= out_off_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_node_id = out_id_r;
  assign out_offset  = out_off_r;
  assign out_status  = out_st_r;

endmodule

// ----- sim/strand_node_interval_checker.sv -----
`timescale 1ns / 1ps

module strand_node_interval_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [snil_pkg::LEN_W-1:0]       in_node_length,
  input  logic [snil_pkg::POS_W-1:0]       in_position,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [snil_pkg::ID_W-1:0] out_node_id,
  input  logic [snil_pkg::POS_W-1:0]       out_offset,
  input  logic [1:0]                       out_status,
  output int                               mismatches,
  output int                               answers_left
);
  import snil_pkg::*;

  typedef struct packed {
    logic signed [ID_W-1:0] node_id;
    logic [POS_W-1:0]       offset;
    logic [1:0]             status;
  } answer_t;

  logic [POS_W-1:0] bounds [TABLE_DEPTH];
  int               n_bounds;
  answer_t          answers_due [$];

  // Updates the boundary table and returns the answer for one item.
  function automatic answer_t apply_request(input logic             req,
                                            input logic [LEN_W-1:0] len,
                                            input logic [POS_W-1:0] pos);
    answer_t        ans;
    logic [POS_W:0] next_end;
    int             slot;
    int             mag;
    ans = '0;
    if (req == REQ_APPEND) begin
      next_end = {1'b0, bounds[n_bounds-1]} + len + 1;
      if (n_bounds >= TABLE_DEPTH) begin
        ans.status = ST_FULL;
      end else if (next_end[POS_W]) begin
        ans.status = ST_OVERFLOW;
      end else begin
        bounds[n_bounds] = next_end[POS_W-1:0];
        n_bounds++;
        ans.status = ST_APPENDED;
      end
    end else begin
      // table is strictly increasing and starts at 0: scan down to the last
      // boundary not above pos
      slot = n_bounds - 1;
      while (bounds[slot] > pos) slot--;
      mag         = slot / 2 + 1;
      ans.node_id = ID_W'((slot % 2 != 0) ? -mag : mag);
      ans.offset  = pos - bounds[slot];
      ans.status  = ST_LOCATED;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t fresh;
    if (!rst_n) begin
      n_bounds   = 1;
      bounds[0]  = '0;
      mismatches = 0;
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item: expected none, got node_id %0d offset %0d status %0d",
                   $time, out_node_id, out_offset, out_status);
        end else begin
          want = answers_due.pop_front();
          if (out_node_id !== want.node_id) begin
            mismatches++;
            $display("%0t: node_id expected %0d, got %0d", $time, want.node_id, out_node_id);
          end
          if (out_offset !== want.offset) begin
            mismatches++;
            $display("%0t: offset expected %0d, got %0d", $time, want.offset, out_offset);
          end
          if (out_status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh = apply_request(in_req_type, in_node_length, in_position);
        answers_due.insert(answers_due.size(), fresh);
      end
    end
    answers_left <= answers_due.size();
  end

endmodule

// ----- sim/strand_node_interval_locator_tb.sv -----
`timescale 1ns / 1ps

module strand_node_interval_locator_tb;
  import snil_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_req_type;
  logic [LEN_W-1:0]       in_node_length;
  logic [POS_W-1:0]       in_position;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [ID_W-1:0] out_node_id;
  logic [POS_W-1:0]       out_offset;
  logic [1:0]             out_status;

  int mismatches;
  int answers_left;

  // set by the stimulus to run both sides flat out for a while
  bit calm;

  // boundaries appended so far; only used to aim locate positions at
  // interesting spots (exact hits, one below, just past)
  logic [POS_W-1:0] ends [$];

  always #5 clk = ~clk;

  strand_node_interval_locator u_dut (.*);

  strand_node_interval_checker u_checker (.*);

  // per-item idle draw, shared by sender and receiver
  function automatic int pick_wait();
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Node lengths: mostly short so boundaries sit close together and random
  // positions land across many slots; zero, all ones and wide random values too.
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(1, 40));
    endcase
  endfunction

  // Positions: exact boundaries, one below, a little past, anywhere up to 1000 past the
  // last boundary, anywhere at all, and the extremes.
  function automatic logic [POS_W-1:0] pick_position();
    logic [POS_W-1:0] b;
    logic [POS_W-1:0] last;
    b    = ends[$urandom_range(0, ends.size() - 1)];
    last = ends[$];
    case ($urandom_range(0, 9))
      0, 1, 2: return b;
      3:       return b - 1;
      4, 5:    return b + $urandom_range(0, 3);
      6, 7:    return $urandom_range(0, last + 32'd1000);
      8:       return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return last;
          default: return last + 1;
        endcase
      end
    endcase
  endfunction

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high across back-to-back items; payload holds while stalled.
  task automatic send(input logic req, input logic [LEN_W-1:0] len,
                      input logic [POS_W-1:0] pos);
    int             gap;
    logic [POS_W:0] next_end;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_node_length <= len;
    in_position    <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    next_end = {1'b0, ends[$]} + len + 1;
    if (req == REQ_APPEND && ends.size() < TABLE_DEPTH && !next_end[POS_W])
      ends.insert(ends.size(), next_end[POS_W-1:0]);
  endtask

  // position field is don't-care on append; drive noise into it
  task automatic append(input logic [LEN_W-1:0] len);
    send(REQ_APPEND, len, $urandom);
  endtask

  task automatic locate(input logic [POS_W-1:0] pos);
    send(REQ_LOCATE, LEN_W'($urandom), pos);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 1))
      locate(pick_position());
    else
      append(pick_length());
  endtask

  // Stimulus
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_APPEND;
    in_node_length = '0;
    in_position    = '0;
    calm           = 1'b0;
    ends.insert(0, '0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // single-entry table: everything falls into slot 0
    locate('0);
    locate('1);
    // shortest and longest nodes
    append('0);
    append('1);
    // exact boundary hits (reverse slot at 1), in between, past last
    locate('0);
    locate(32'd1);
    locate(32'd2);
    locate(32'h0010_0000);
    locate(32'h0010_0001);
    locate(32'h0010_0002);
    locate(32'hFFFF_FFFF);
    // alternating bit patterns in the length field
    append(20'h55555);
    append(20'hAAAAA);
    append(20'd1);
    locate(ends[3]);
    locate(ends[3] - 1);
    locate(ends[4]);
    locate(ends[5]);
    locate(ends[5] + 1);
    locate(32'h5555_5555);
    locate(32'hAAAA_AAAA);
    locate(32'h8000_0000);

    // random mix while the table grows; one stretch with no idling
    for (int i = 0; i < 620; i++) begin
      calm = (i >= 200 && i < 280);
      random_item();
    end
    calm = 1'b0;

    // deepest searches on the grown table
    locate('1);
    locate('0);
    locate(ends[$]);
    locate(ends[$] - 1);
    locate(ends[ends.size()-2]);
    locate(ends[ends.size()-2] + 1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_left != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("[strand_node_interval_locator] OK");
    else
      $display("[strand_node_interval_locator] ERROR");
    $finish;
  end

  // Result side: random stall per item; one long hold-off early on so the
  // block backs up and stalls the sender.
  initial begin
    int hold;
    int taken;
    out_stall = 1'b0;
    taken     = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = (taken == 30) ? 400 : pick_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog: well beyond the slowest legal run of about 650 items
  initial begin
    #1_000_000;
    $display("[strand_node_interval_locator] ERROR");
    $finish;
  end

endmodule
